FILE: sv/lbms_pkg.sv
// Shared types, codes and a hash helper function for the bond member selector.
package lbms_pkg;

   localparam int DATA_W      = 32;
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = DATA_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);
   localparam int SLOT_W      = 3;
   localparam int COUNT_W     = 4;
   localparam int PORT_W      = 16;

   localparam logic [1:0] CMD_SEND        = 2'd0;
   localparam logic [1:0] CMD_LINK_UP     = 2'd1;
   localparam logic [1:0] CMD_LINK_DOWN   = 2'd2;
   localparam logic [1:0] CMD_SET_PRIMARY = 2'd3;

   localparam logic [2:0] MODE_ROUND_ROBIN = 3'd0;
   localparam logic [2:0] MODE_XOR_HASH    = 3'd2;
   localparam logic [2:0] MODE_RESET       = 3'd2;

   localparam logic [2:0] POLICY_IP_PORT  = 3'd1;
   localparam logic [2:0] POLICY_IP_TIMES = 3'd2;
   localparam logic [2:0] POLICY_RESET    = 3'd1;

   localparam logic REG_BOND_MODE   = 1'b0;
   localparam logic REG_HASH_POLICY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } state_type;

   function automatic logic [DATA_W-1:0] dest_hash(input logic [2:0] policy,
                                                   input logic [DATA_W-1:0] ip,
                                                   input logic [PORT_W-1:0] port);
      logic [DATA_W-1:0] h;
      case (policy)
         POLICY_IP_PORT:  h = ip ^ {port, {(DATA_W-PORT_W){1'b0}}};
         POLICY_IP_TIMES: h = (ip << 5) - ip;
         default:         h = ip;
      endcase
      return h;
   endfunction

endpackage

FILE: sv/lbms_req_if.sv
// Handshake interfaces for the request and response channels.
interface lbms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [2:0]  member;
   logic [31:0] dest_ip;
   logic [15:0] dest_port;

   modport source (output valid, cmd, member, dest_ip, dest_port, input ready);
   modport sink   (input valid, cmd, member, dest_ip, dest_port, output ready);
endinterface

interface lbms_rsp_if;
   logic       valid;
   logic       ready;
   logic       cmd_ok;
   logic [2:0] chosen_member;
   logic       no_member;
   logic [2:0] primary_member;
   logic       failover;
   logic [3:0] active_count;

   modport source (output valid, cmd_ok, chosen_member, no_member, primary_member,
                   failover, active_count, input ready);
   modport sink   (input valid, cmd_ok, chosen_member, no_member, primary_member,
                   failover, active_count, output ready);
endinterface

FILE: sv/lbms_mod.sv
// Iterative modulo unit: four restoring steps per cycle over a 32-bit dividend.
module lbms_mod #(
   parameter int CW = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lbms_pkg::DATA_W-1:0] dividend,
   input  logic [CW-1:0]               divisor,
   output logic                        done,
   output logic [CW-1:0]               remainder
);

   logic                             busy_ff, busy_in;
   logic [lbms_pkg::DIGIT_CNT_W-1:0] digit_ff, digit_in;
   logic [lbms_pkg::DATA_W-1:0]      dvd_ff, dvd_in;
   logic [CW-1:0]                    div_ff, div_in;
   logic [CW-1:0]                    rem_ff, rem_in;
   logic [CW-1:0]                    rem_next;

   always_comb begin
      logic [CW:0] t;
      rem_next = rem_ff;
      for (int k = 0; k < lbms_pkg::DIGIT_W; k++) begin
         t = {rem_next, dvd_ff[lbms_pkg::DATA_W-1-k]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         rem_next = CW'(t);
      end
   end

   assign done      = busy_ff && (digit_ff == lbms_pkg::DIGIT_CNT_W'(lbms_pkg::DIGITS - 1));
   assign remainder = rem_next;

   always_comb begin
      busy_in  = busy_ff;
      digit_in = digit_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         digit_in = '0;
         dvd_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = dvd_ff << lbms_pkg::DIGIT_W;
         rem_in   = rem_next;
         digit_in = digit_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         digit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         digit_ff <= digit_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: sv/link_bond_member_select_top.sv
// Top level of the bond member selector: state, sequencer and register port.
//
//  Channel | Direction | Handshake             | Payload
//  req_ch  | in        | valid / ready         | cmd, member, dest_ip, dest_port
//  rsp_ch  | out       | valid / ready         | cmd_ok ... active_count
//  APB     | in        | psel, penable, pready | bond_mode, hash_policy
//
// Link up and set primary go from acceptance straight to the done state, which registers
// the result; taking the primary down, or a primary-first send with no live primary, runs
// the scan first. Round robin and hash sends run the modulo unit (4 bits per cycle) before the scan.
// req ready is high only while the sequencer is idle; a held response keeps the next
// item in its last state, which holds off further requests. Reset is synchronous.
module link_bond_member_select_top #(
   parameter int MEMBERS = 8
) (
   input  logic               clock,
   input  logic               reset,
   lbms_req_if.sink           req_ch,
   lbms_rsp_if.source         rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int CW = $clog2(MEMBERS + 1);
   localparam int SW = $clog2(MEMBERS);

   lbms_pkg::state_type state_ff, state_in;

   logic [2:0]                  mode_ff, mode_in;
   logic [2:0]                  policy_ff, policy_in;
   logic [MEMBERS-1:0]          mask_ff, mask_in;
   logic [lbms_pkg::SLOT_W-1:0] primary_ff, primary_in;
   logic                        pvalid_ff, pvalid_in;
   logic [lbms_pkg::DATA_W-1:0] rr_ff, rr_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic                        ok_ff, ok_in;
   logic [lbms_pkg::SLOT_W-1:0] chosen_ff, chosen_in;
   logic                        none_ff, none_in;
   logic                        fail_ff, fail_in;

   logic                        rvalid_ff, rvalid_in;
   logic                        rok_ff, rok_in;
   logic [lbms_pkg::SLOT_W-1:0] rchosen_ff, rchosen_in;
   logic                        rnone_ff, rnone_in;
   logic [lbms_pkg::SLOT_W-1:0] rprimary_ff, rprimary_in;
   logic                        rfail_ff, rfail_in;
   logic [lbms_pkg::COUNT_W-1:0] rcount_ff, rcount_in;

   logic [CW-1:0]               count;
   logic [MEMBERS-1:0]          member_bit;
   logic                        in_range;
   logic                        primary_ok;
   logic                        accept;
   logic                        mod_start;
   logic                        mod_done;
   logic [CW-1:0]               mod_rem;
   logic [lbms_pkg::DATA_W-1:0] mod_dividend;
   logic                        is_send;
   logic                        mod_mode;
   logic                        scan_hit;
   logic                        scan_last;
   logic                        out_free;
   logic                        cfg_write;

   always_comb begin
      count = '0;
      for (int s = 0; s < MEMBERS; s++) begin
         count = count + CW'(mask_ff[s]);
      end
   end

   assign member_bit = MEMBERS'(1) << req_ch.member;
   assign in_range   = 32'(req_ch.member) < MEMBERS;
   assign primary_ok = pvalid_ff && |(mask_ff & (MEMBERS'(1) << primary_ff));
   assign accept     = req_ch.valid && req_ch.ready;
   assign is_send    = req_ch.cmd == lbms_pkg::CMD_SEND;
   assign mod_mode   = (mode_ff == lbms_pkg::MODE_ROUND_ROBIN) ||
                       (mode_ff == lbms_pkg::MODE_XOR_HASH);
   assign mod_start  = accept && is_send && (count != '0) && mod_mode;
   assign mod_dividend = (mode_ff == lbms_pkg::MODE_ROUND_ROBIN) ? rr_ff :
                         lbms_pkg::dest_hash(policy_ff, req_ch.dest_ip, req_ch.dest_port);
   assign scan_hit   = mask_ff[slot_ff] && (pos_ff == '0);
   assign scan_last  = slot_ff == SW'(MEMBERS - 1);
   assign out_free   = !rvalid_ff || rsp_ch.ready;
   assign cfg_write  = psel && penable && pwrite && pready;

   lbms_mod #(.CW(CW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (count),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbms_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               if (is_send && (count != '0) && mod_mode) begin
                  state_in = lbms_pkg::ST_MOD;
               end else if (is_send && (count != '0) && !primary_ok) begin
                  state_in = lbms_pkg::ST_SCAN;
               end else if ((req_ch.cmd == lbms_pkg::CMD_LINK_DOWN) && in_range &&
                            pvalid_ff && (primary_ff == req_ch.member)) begin
                  state_in = lbms_pkg::ST_SCAN;
               end else begin
                  state_in = lbms_pkg::ST_DONE;
               end
            end
         end
         lbms_pkg::ST_MOD: begin
            if (mod_done) begin
               state_in = lbms_pkg::ST_SCAN;
            end
         end
         lbms_pkg::ST_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = lbms_pkg::ST_DONE;
            end
         end
         lbms_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lbms_pkg::ST_IDLE;
            end
         end
         default: state_in = lbms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mask_in     = mask_ff;
      primary_in  = primary_ff;
      pvalid_in   = pvalid_ff;
      rr_in       = rr_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      slot_in     = slot_ff;
      ok_in       = ok_ff;
      chosen_in   = chosen_ff;
      none_in     = none_ff;
      fail_in     = fail_ff;
      rvalid_in   = rvalid_ff && !rsp_ch.ready;
      rok_in      = rok_ff;
      rchosen_in  = rchosen_ff;
      rnone_in    = rnone_ff;
      rprimary_in = rprimary_ff;
      rfail_in    = rfail_ff;
      rcount_in   = rcount_ff;
      case (state_ff)
         lbms_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.cmd;
               ok_in     = 1'b0;
               chosen_in = '0;
               none_in   = 1'b0;
               fail_in   = 1'b0;
               slot_in   = '0;
               pos_in    = '0;
               if (is_send) begin
                  if (count == '0) begin
                     none_in = 1'b1;
                  end else begin
                     ok_in = 1'b1;
                     if (mode_ff == lbms_pkg::MODE_ROUND_ROBIN) begin
                        rr_in = rr_ff + 1'b1;
                     end else if (!mod_mode && primary_ok) begin
                        chosen_in = primary_ff;
                     end
                  end
               end else if (in_range) begin
                  case (req_ch.cmd)
                     lbms_pkg::CMD_LINK_UP: begin
                        mask_in = mask_ff | member_bit;
                        ok_in   = 1'b1;
                        if (!pvalid_ff) begin
                           primary_in = req_ch.member;
                           pvalid_in  = 1'b1;
                        end
                     end
                     lbms_pkg::CMD_LINK_DOWN: begin
                        mask_in = mask_ff & ~member_bit;
                        ok_in   = 1'b1;
                     end
                     default: begin
                        if (|(mask_ff & member_bit)) begin
                           primary_in = req_ch.member;
                           pvalid_in  = 1'b1;
                           ok_in      = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         lbms_pkg::ST_MOD: begin
            if (mod_done) begin
               pos_in = mod_rem;
            end
         end
         lbms_pkg::ST_SCAN: begin
            slot_in = slot_ff + 1'b1;
            if (mask_ff[slot_ff]) begin
               if (pos_ff == '0) begin
                  if (cmd_ff == lbms_pkg::CMD_SEND) begin
                     chosen_in = lbms_pkg::SLOT_W'(slot_ff);
                  end else begin
                     primary_in = lbms_pkg::SLOT_W'(slot_ff);
                     fail_in    = 1'b1;
                  end
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         lbms_pkg::ST_DONE: begin
            if (out_free) begin
               rvalid_in   = 1'b1;
               rok_in      = ok_ff;
               rchosen_in  = chosen_ff;
               rnone_in    = none_ff;
               rprimary_in = primary_ff;
               rfail_in    = fail_ff;
               rcount_in   = lbms_pkg::COUNT_W'(count);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      policy_in = policy_ff;
      if (cfg_write) begin
         if (paddr[2] == lbms_pkg::REG_HASH_POLICY) begin
            policy_in = pwdata[2:0];
         end else begin
            mode_in = pwdata[2:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = {29'd0, (paddr[2] == lbms_pkg::REG_BOND_MODE) ? mode_ff : policy_ff};

   assign req_ch.ready          = state_ff == lbms_pkg::ST_IDLE;
   assign rsp_ch.valid          = rvalid_ff;
   assign rsp_ch.cmd_ok         = rok_ff;
   assign rsp_ch.chosen_member  = rchosen_ff;
   assign rsp_ch.no_member      = rnone_ff;
   assign rsp_ch.primary_member = rprimary_ff;
   assign rsp_ch.failover       = rfail_ff;
   assign rsp_ch.active_count   = rcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lbms_pkg::ST_IDLE;
         mode_ff    <= lbms_pkg::MODE_RESET;
         policy_ff  <= lbms_pkg::POLICY_RESET;
         mask_ff    <= '0;
         primary_ff <= '0;
         pvalid_ff  <= 1'b0;
         rr_ff      <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         policy_ff  <= policy_in;
         mask_ff    <= mask_in;
         primary_ff <= primary_in;
         pvalid_ff  <= pvalid_in;
         rr_ff      <= rr_in;
         rvalid_ff  <= rvalid_in;
      end
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      slot_ff     <= slot_in;
      ok_ff       <= ok_in;
      chosen_ff   <= chosen_in;
      none_ff     <= none_in;
      fail_ff     <= fail_in;
      rok_ff      <= rok_in;
      rchosen_ff  <= rchosen_in;
      rnone_ff    <= rnone_in;
      rprimary_ff <= rprimary_in;
      rfail_ff    <= rfail_in;
      rcount_ff   <= rcount_in;
   end

endmodule

FILE: sv/lbms_checker.sv
// Port-level checks for the bond member selector, bound to the top level.
module lbms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_cmd_ok,
   input logic [2:0] rsp_chosen_member,
   input logic       rsp_no_member,
   input logic       rsp_failover,
   input logic [3:0] rsp_active_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   a_no_member: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_member |-> !rsp_cmd_ok && (rsp_chosen_member == 3'd0) &&
                                     (rsp_active_count == 4'd0))
      else $error("no-member result is inconsistent");

   a_failover_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failover |-> rsp_cmd_ok && !rsp_no_member)
      else $error("failover reported on a refused command");

endmodule

bind link_bond_member_select_top lbms_checker u_lbms_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_cmd_ok        (rsp_ch.cmd_ok),
   .rsp_chosen_member (rsp_ch.chosen_member),
   .rsp_no_member     (rsp_ch.no_member),
   .rsp_failover      (rsp_ch.failover),
   .rsp_active_count  (rsp_ch.active_count)
);
